/* rtl/gtct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package gtct_pkg;

	localparam int unsigned CNT_W = 16;
	localparam int unsigned SUM_W = 17;
	localparam int unsigned MODE_W = 13;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned IRQ_W = 3;

	typedef logic [1:0] req_t;
	localparam req_t REQ_READ = 2'd0;
	localparam req_t REQ_WRITE = 2'd1;
	localparam req_t REQ_TICKS = 2'd2;
	localparam req_t REQ_GATE = 2'd3;

	typedef logic [3:0] port_t;
	localparam port_t PORT_COUNT = 4'h0;
	localparam port_t PORT_MODE = 4'h4;
	localparam port_t PORT_TARGET = 4'h8;

	localparam int unsigned M_SYNC_EN = 0;
	localparam int unsigned M_RESET_TGT = 3;
	localparam int unsigned M_IRQ_TGT = 4;
	localparam int unsigned M_IRQ_OVF = 5;
	localparam int unsigned M_CLK_SRC0 = 8;
	localparam int unsigned M_CLK_SRC1 = 9;
	localparam int unsigned M_IRQ_REQ = 10;
	localparam int unsigned M_REACH_TGT = 11;
	localparam int unsigned M_REACH_OVF = 12;

	localparam logic [1:0] SYNC_PAUSE = 2'd0;
	localparam logic [1:0] SYNC_RESET = 2'd1;
	localparam logic [1:0] SYNC_GATED = 2'd2;
	localparam logic [1:0] SYNC_FREE = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic cen;
		logic ext;
	} enables_t;

	function automatic enables_t refresh_enable(logic [MODE_W-1:0] mode, logic gate,
			logic ext_chosen);
		enables_t e;
		e.cen = 1'b1;
		if (mode[M_SYNC_EN]) begin
			case (mode[2:1])
				SYNC_PAUSE, SYNC_FREE: e.cen = !gate;
				SYNC_RESET: e.cen = 1'b1;
				default: e.cen = gate;
			endcase
		end
		e.ext = ext_chosen && e.cen;
		return e;
	endfunction

endpackage
`default_nettype wire

/* rtl/gated_triple_counter_timer.sv */
// Three 16-bit counter/timers with gate sync modes, driven by request items.
// Input channel (in_valid/in_stall): one request per transfer: a register
// read, a register write, a batch of system ticks or a gate level change.
// Output channel (out_valid/out_stall): exactly one result per request, in
// order, carrying read_data and the per-timer irq_mask.
// A read, write or gate change passes S_EXEC and S_DONE before its result is loaded.
// A tick batch walks the timers one after another; a timer that wraps runs
// a bit-serial divider for the remainder, and timer 2 on the external clock
// first divides the batch by the prescaler on the same divider; the one divider
// is shared by both uses.
// Reset clears all counters, targets and modes and enables counting.
// The output register holds its result while out_stall is high; the next
// request is accepted meanwhile and its result waits until the output frees.
`timescale 1ns / 1ps
`default_nettype none
module gated_triple_counter_timer #(
	parameter int unsigned NUM_TIMERS = 3,
	parameter int unsigned PRESCALE_DIVISOR = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] req_type,
	input wire logic [5:0] reg_address,
	input wire logic [31:0] write_data,
	input wire logic [15:0] tick_count,
	input wire logic [1:0] gate_timer,
	input wire logic gate_level,
	output logic out_valid,
	input wire logic out_stall,
	output logic [31:0] read_data,
	output logic [2:0] irq_mask
);
	import gtct_pkg::*;

	localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_PREW = 3'd2;
	localparam logic [2:0] S_TICK = 3'd3;
	localparam logic [2:0] S_DIVW = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [IW-1:0] k_q;

	req_t req_q;
	logic [5:0] addr_q;
	logic [DATA_W-1:0] wdata_q;
	logic [CNT_W-1:0] ticks_q;
	logic [1:0] gt_q;
	logic gl_q;
	logic [CNT_W-1:0] pre_q;

	logic [CNT_W-1:0] count_q [NUM_TIMERS];
	logic [CNT_W-1:0] target_q [NUM_TIMERS];
	logic [MODE_W-1:0] mode_q [NUM_TIMERS];
	logic gate_q [NUM_TIMERS];
	logic cen_q [NUM_TIMERS];
	logic ext_q [NUM_TIMERS];
	logic extsel_q [NUM_TIMERS];

	logic [DATA_W-1:0] res_rd_q;
	logic [IRQ_W-1:0] res_irq_q;
	logic out_valid_q;
	logic [DATA_W-1:0] rdata_q;
	logic [IRQ_W-1:0] irq_q;

	logic div_start;
	logic [SUM_W-1:0] div_dvd;
	logic [CNT_W-1:0] div_dsr;
	logic div_done;
	logic [SUM_W-1:0] div_quo;
	logic [CNT_W-1:0] div_rem;

	logic [1:0] t_idx;
	port_t port;
	logic t_ok;
	logic g_ok;
	logic [1:0] tk;
	logic tk_en;
	logic [SUM_W-1:0] csum;
	logic [CNT_W-1:0] rv;
	logic [MODE_W-1:0] mode_new;
	logic irq_new;
	logic pre_need;
	logic [DATA_W-1:0] rd_val;

	assign t_idx = addr_q[5:4];
	assign port = addr_q[3:0];
	assign t_ok = {1'b0, t_idx} < 3'(NUM_TIMERS);
	assign g_ok = {1'b0, gt_q} < 3'(NUM_TIMERS);
	assign tk = 2'(k_q);
	assign pre_need = (NUM_TIMERS > 2) && cen_q[IW'(2)] && ext_q[IW'(2)];

	always_comb begin
		rd_val = '1;
		if (t_ok) begin
			case (port)
				PORT_COUNT: rd_val = {16'h0, count_q[t_idx[IW-1:0]]};
				PORT_MODE: rd_val = {19'h0, mode_q[t_idx[IW-1:0]]};
				PORT_TARGET: rd_val = {16'h0, target_q[t_idx[IW-1:0]]};
				default: rd_val = '1;
			endcase
		end
	end

	always_comb begin
		tk_en = cen_q[k_q] && ((tk == 2'd2) || !ext_q[k_q]);
		csum = {1'b0, count_q[k_q]} +
			{1'b0, ((tk == 2'd2) && ext_q[k_q]) ? pre_q : ticks_q};
		rv = mode_q[k_q][M_RESET_TGT] ? target_q[k_q] : CNT_MAX;
		mode_new = mode_q[k_q];
		if (csum >= {1'b0, target_q[k_q]})
			mode_new[M_REACH_TGT] = 1'b1;
		if (csum >= {1'b0, CNT_MAX})
			mode_new[M_REACH_OVF] = 1'b1;
		irq_new = (mode_new[M_REACH_TGT] && mode_new[M_IRQ_TGT]) ||
			(mode_new[M_REACH_OVF] && mode_new[M_IRQ_OVF]);
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd = {1'b0, ticks_q};
		div_dsr = CNT_W'(PRESCALE_DIVISOR);
		if (state_q == S_EXEC && req_q == REQ_TICKS && pre_need) begin
			div_start = 1'b1;
		end else if (state_q == S_TICK && tk_en && csum >= {1'b0, rv} && rv != '0) begin
			div_start = 1'b1;
			div_dvd = csum;
			div_dsr = rv;
		end
	end

	gtct_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dsr),
		.done(div_done),
		.quotient(div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_q <= req_type;
			addr_q <= reg_address;
			wdata_q <= write_data;
			ticks_q <= tick_count;
			gt_q <= gate_timer;
			gl_q <= gate_level;
		end
		if (state_q == S_PREW && div_done)
			pre_q <= div_quo[CNT_W-1:0];
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			rdata_q <= res_rd_q;
			irq_q <= res_irq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			out_valid_q <= 1'b0;
			res_rd_q <= '0;
			res_irq_q <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				count_q[i] <= '0;
				target_q[i] <= '0;
				mode_q[i] <= '0;
				gate_q[i] <= 1'b0;
				cen_q[i] <= 1'b1;
				ext_q[i] <= 1'b0;
				extsel_q[i] <= 1'b0;
			end
		end else begin
			if (state_q == S_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					res_rd_q <= (req_q == REQ_READ) ? rd_val : '0;
					res_irq_q <= '0;
					k_q <= '0;
					state_q <= (req_q == REQ_TICKS) ? (pre_need ? S_PREW : S_TICK) : S_DONE;
					case (req_q)
						REQ_READ: begin
							if (t_ok && port == PORT_MODE) begin
								mode_q[t_idx[IW-1:0]][M_REACH_TGT] <= 1'b0;
								mode_q[t_idx[IW-1:0]][M_REACH_OVF] <= 1'b0;
							end
						end
						REQ_WRITE: begin
							if (t_ok) begin
								case (port)
									PORT_COUNT: count_q[t_idx[IW-1:0]] <= wdata_q[CNT_W-1:0];
									PORT_MODE: begin
										mode_q[t_idx[IW-1:0]] <= wdata_q[MODE_W-1:0];
										extsel_q[t_idx[IW-1:0]] <= (t_idx == 2'd2) ?
											wdata_q[M_CLK_SRC1] : wdata_q[M_CLK_SRC0];
										count_q[t_idx[IW-1:0]] <= '0;
										{cen_q[t_idx[IW-1:0]], ext_q[t_idx[IW-1:0]]} <=
											refresh_enable(wdata_q[MODE_W-1:0],
												gate_q[t_idx[IW-1:0]],
												(t_idx == 2'd2) ? wdata_q[M_CLK_SRC1] :
												wdata_q[M_CLK_SRC0]);
									end
									PORT_TARGET: target_q[t_idx[IW-1:0]] <= wdata_q[CNT_W-1:0];
									default: ;
								endcase
							end
						end
						REQ_TICKS: ;
						default: begin
							if (g_ok && gate_q[gt_q[IW-1:0]] != gl_q) begin
								gate_q[gt_q[IW-1:0]] <= gl_q;
								if (mode_q[gt_q[IW-1:0]][M_SYNC_EN]) begin
									if (gl_q && (mode_q[gt_q[IW-1:0]][2:1] == SYNC_RESET ||
											mode_q[gt_q[IW-1:0]][2:1] == SYNC_GATED))
										count_q[gt_q[IW-1:0]] <= '0;
									if (gl_q && mode_q[gt_q[IW-1:0]][2:1] == SYNC_FREE) begin
										mode_q[gt_q[IW-1:0]][M_SYNC_EN] <= 1'b0;
										{cen_q[gt_q[IW-1:0]], ext_q[gt_q[IW-1:0]]} <=
											refresh_enable({mode_q[gt_q[IW-1:0]][MODE_W-1:1],
												1'b0}, gl_q, extsel_q[gt_q[IW-1:0]]);
									end else begin
										{cen_q[gt_q[IW-1:0]], ext_q[gt_q[IW-1:0]]} <=
											refresh_enable(mode_q[gt_q[IW-1:0]], gl_q,
												extsel_q[gt_q[IW-1:0]]);
									end
								end
							end
						end
					endcase
				end
				S_PREW: begin
					if (div_done)
						state_q <= S_TICK;
				end
				S_TICK: begin
					if (tk_en && csum < {1'b0, rv}) begin
						count_q[k_q] <= csum[CNT_W-1:0];
					end else if (tk_en) begin
						mode_q[k_q] <= mode_new;
						if (!mode_q[k_q][M_IRQ_REQ] && irq_new && tk != 2'd3)
							res_irq_q[tk] <= 1'b1;
						if (rv == '0)
							count_q[k_q] <= '0;
					end
					if (div_start) begin
						state_q <= S_DIVW;
					end else if (k_q == IW'(NUM_TIMERS - 1)) begin
						state_q <= S_DONE;
					end else begin
						k_q <= k_q + IW'(1);
					end
				end
				S_DIVW: begin
					if (div_done) begin
						count_q[k_q] <= div_rem;
						if (k_q == IW'(NUM_TIMERS - 1))
							state_q <= S_DONE;
						else begin
							k_q <= k_q + IW'(1);
							state_q <= S_TICK;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign read_data = rdata_q;
	assign irq_mask = irq_q;

`ifndef SYNTHESIS
	a_div_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == S_EXEC || state_q == S_TICK))
		else $error("divider started outside tick processing");
	a_irq_only_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_irq_q != '0) |-> (req_q == REQ_TICKS))
		else $error("interrupt raised by a non-tick request");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!out_valid_q || !out_stall)) |=> out_valid_q)
		else $error("finished result not presented");
`endif
endmodule
`default_nettype wire

/* rtl/gtct_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module gtct_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [gtct_pkg::SUM_W-1:0] dividend,
	input wire logic [gtct_pkg::CNT_W-1:0] divisor,
	output logic done,
	output logic [gtct_pkg::SUM_W-1:0] quotient,
	output logic [gtct_pkg::CNT_W-1:0] remainder
);
	import gtct_pkg::*;

	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [SUM_W-1:0] dvd_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dsr_q;
	logic [SUM_W-1:0] trial;
	logic ge;

	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign ge = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? CNT_W'(trial - {1'b0, dsr_q}) : trial[CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider finished without running");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < dsr_q))
		else $error("remainder not below divisor");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
`endif
endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
	import gtct_pkg::*;

	localparam int unsigned TIMERS = 3;
	localparam int unsigned PRESCALE = 8;
	localparam int unsigned RANDOM_ITEMS = 1400;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned HOLD_CYCLES = 400;

	typedef struct {
		req_t req;
		logic [5:0] addr;
		logic [31:0] wdata;
		logic [15:0] ticks;
		logic [1:0] gtimer;
		logic glevel;
	} request_t;

	typedef struct {
		logic [31:0] rdata;
		logic [2:0] irq;
	} outcome_t;

	typedef struct {
		request_t rq;
		logic typed;
		logic [31:0] rdata;
		logic [2:0] irq;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic [5:0] reg_address = '0;
	logic [31:0] write_data = '0;
	logic [15:0] tick_count = '0;
	logic [1:0] gate_timer = '0;
	logic gate_level = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] read_data;
	logic [2:0] irq_mask;

	logic [CNT_W-1:0] cnt [TIMERS];
	logic [CNT_W-1:0] tgt [TIMERS];
	logic [MODE_W-1:0] mode [TIMERS];
	logic gate_seen [TIMERS];
	logic cen [TIMERS];
	logic ext_en [TIMERS];
	logic ext_sel [TIMERS];

	outcome_t pending_results[$];
	int unsigned mismatches = 0;
	int unsigned accepted = 0;
	int unsigned cycles = 0;
	logic idling_on = 1'b1;
	logic hold_done = 1'b0;
	logic stimulus_done = 1'b0;

	gated_triple_counter_timer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.reg_address(reg_address),
		.write_data(write_data),
		.tick_count(tick_count),
		.gate_timer(gate_timer),
		.gate_level(gate_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.irq_mask(irq_mask)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void timers_clear();
		for (int t = 0; t < TIMERS; t++) begin
			cnt[t] = '0;
			tgt[t] = '0;
			mode[t] = '0;
			gate_seen[t] = 1'b0;
			cen[t] = 1'b1;
			ext_en[t] = 1'b0;
			ext_sel[t] = 1'b0;
		end
	endfunction

	function automatic void enables_update(int t);
		logic c;
		c = 1'b1;
		if (mode[t][M_SYNC_EN]) begin
			case (mode[t][2:1])
				SYNC_PAUSE, SYNC_FREE: c = !gate_seen[t];
				SYNC_RESET: c = 1'b1;
				default: c = gate_seen[t];
			endcase
		end
		cen[t] = c;
		ext_en[t] = ext_sel[t] && c;
	endfunction

	function automatic logic timer_advance(int t, int unsigned n);
		int unsigned sum;
		int unsigned wrap;
		logic old_irq;
		logic new_irq;
		sum = cnt[t] + n;
		wrap = mode[t][M_RESET_TGT] ? tgt[t] : 32'hFFFF;
		if (sum < wrap) begin
			cnt[t] = sum[15:0];
			return 1'b0;
		end
		old_irq = mode[t][M_IRQ_REQ];
		if (sum >= tgt[t]) mode[t][M_REACH_TGT] = 1'b1;
		if (sum >= 32'hFFFF) mode[t][M_REACH_OVF] = 1'b1;
		new_irq = (mode[t][M_REACH_TGT] && mode[t][M_IRQ_TGT]) ||
			(mode[t][M_REACH_OVF] && mode[t][M_IRQ_OVF]);
		cnt[t] = (wrap > 0) ? 16'(sum % wrap) : '0;
		return !old_irq && new_irq;
	endfunction

	function automatic outcome_t timers_predict(request_t rq);
		outcome_t o;
		int t;
		port_t p;
		t = rq.addr[5:4];
		p = rq.addr[3:0];
		o.rdata = '0;
		o.irq = '0;
		case (rq.req)
			REQ_READ: begin
				o.rdata = 32'hFFFF_FFFF;
				if (t < TIMERS) begin
					if (p == PORT_COUNT) begin
						o.rdata = 32'(cnt[t]);
					end else if (p == PORT_MODE) begin
						o.rdata = 32'(mode[t]);
						mode[t][M_REACH_TGT] = 1'b0;
						mode[t][M_REACH_OVF] = 1'b0;
					end else if (p == PORT_TARGET) begin
						o.rdata = 32'(tgt[t]);
					end
				end
			end
			REQ_WRITE: begin
				if (t < TIMERS) begin
					if (p == PORT_COUNT) begin
						cnt[t] = rq.wdata[15:0];
					end else if (p == PORT_MODE) begin
						mode[t] = rq.wdata[MODE_W-1:0];
						ext_sel[t] = (t == 2) ? mode[t][M_CLK_SRC1] : mode[t][M_CLK_SRC0];
						cnt[t] = '0;
						enables_update(t);
					end else if (p == PORT_TARGET) begin
						tgt[t] = rq.wdata[15:0];
					end
				end
			end
			REQ_TICKS: begin
				for (int k = 0; k < TIMERS; k++) begin
					if (k == 2) begin
						if (cen[k] && timer_advance(k,
								ext_en[k] ? rq.ticks / PRESCALE : rq.ticks))
							o.irq[k] = 1'b1;
					end else if (!ext_en[k] && cen[k] && timer_advance(k, rq.ticks)) begin
						o.irq[k] = 1'b1;
					end
				end
			end
			default: begin
				t = rq.gtimer;
				if (t < TIMERS && gate_seen[t] != rq.glevel) begin
					gate_seen[t] = rq.glevel;
					if (mode[t][M_SYNC_EN]) begin
						if (rq.glevel) begin
							if (mode[t][2:1] == SYNC_RESET || mode[t][2:1] == SYNC_GATED)
								cnt[t] = '0;
							else if (mode[t][2:1] == SYNC_FREE)
								mode[t][M_SYNC_EN] = 1'b0;
						end
						enables_update(t);
					end
				end
			end
		endcase
		return o;
	endfunction

	function automatic request_t make_rq(req_t r, logic [5:0] a, logic [31:0] d,
			logic [15:0] n, logic [1:0] g, logic l);
		request_t rq;
		rq.req = r;
		rq.addr = a;
		rq.wdata = d;
		rq.ticks = n;
		rq.gtimer = g;
		rq.glevel = l;
		return rq;
	endfunction

	task automatic issue(request_t rq, logic typed, logic [31:0] rd, logic [2:0] irq);
		outcome_t o;
		while (idling_on && $urandom_range(99) < 38) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		req_type = rq.req;
		reg_address = rq.addr;
		write_data = rq.wdata;
		tick_count = rq.ticks;
		gate_timer = rq.gtimer;
		gate_level = rq.glevel;
		do @(posedge clk); while (in_stall);
		o = timers_predict(rq);
		if (typed) begin
			o.rdata = rd;
			o.irq = irq;
		end
		pending_results.push_back(o);
		accepted++;
		@(negedge clk);
	endtask

	function automatic request_t random_rq();
		request_t rq;
		int unsigned pick;
		logic [1:0] t;
		rq = make_rq(REQ_READ, 6'($urandom), $urandom, 16'($urandom), 2'($urandom),
			1'($urandom));
		t = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
		pick = $urandom_range(99);
		if (pick < 22) begin
			rq.req = REQ_READ;
			if (pick < 19) rq.addr = {t, PORT_COUNT | 4'($urandom_range(2) * 4)};
		end else if (pick < 50) begin
			rq.req = REQ_WRITE;
			if (pick < 47) rq.addr = {t, PORT_COUNT | 4'($urandom_range(2) * 4)};
			if (rq.addr[3:0] == PORT_TARGET && $urandom_range(3) != 0)
				rq.wdata[15:0] = 16'($urandom_range(300));
			if (rq.addr[3:0] == PORT_COUNT && $urandom_range(1) == 0)
				rq.wdata[15:0] = 16'hFFFF - 16'($urandom_range(200));
			if (rq.addr[3:0] == PORT_MODE && $urandom_range(3) != 0)
				rq.wdata[12:10] = '0;
		end else if (pick < 82) begin
			rq.req = REQ_TICKS;
			if ($urandom_range(3) != 0) rq.ticks = 16'($urandom_range(400));
		end else begin
			rq.req = REQ_GATE;
		end
		return rq;
	endfunction

	row_t rows [$];

	initial begin
		timers_clear();
		rows = '{
			'{make_rq(REQ_READ, {2'd0, PORT_COUNT}, '0, '0, '0, 0), 1, 32'h0, 3'h0},
			'{make_rq(REQ_READ, {2'd1, PORT_MODE}, '0, '0, '0, 0), 1, 32'h0, 3'h0},
			'{make_rq(REQ_READ, {2'd3, PORT_COUNT}, '0, '0, '0, 0), 1, 32'hFFFF_FFFF, 3'h0},
			'{make_rq(REQ_READ, {2'd0, 4'hC}, '0, '0, '0, 0), 1, 32'hFFFF_FFFF, 3'h0},
			'{make_rq(REQ_WRITE, {2'd3, PORT_TARGET}, 32'hFFFF_FFFF, '0, '0, 0), 1, 32'h0, 3'h0},
			'{make_rq(REQ_WRITE, {2'd0, PORT_TARGET}, 32'h5, '0, '0, 0), 0, '0, '0},
			'{make_rq(REQ_WRITE, {2'd0, PORT_MODE}, 32'h18, '0, '0, 0), 0, '0, '0},
			'{make_rq(REQ_TICKS, '0, '0, 16'd7, '0, 0), 0, '0, '0},
			'{make_rq(REQ_READ, {2'd0, PORT_MODE}, '0, '0, '0, 0), 0, '0, '0},
			'{make_rq(REQ_READ, {2'd0, PORT_MODE}, '0, '0, '0, 0), 0, '0, '0},
			'{make_rq(REQ_WRITE, {2'd1, PORT_MODE}, 32'h20, '0, '0, 0), 0, '0, '0},
			'{make_rq(REQ_WRITE, {2'd1, PORT_COUNT}, 32'hFFFF_FFFF, '0, '0, 0), 0, '0, '0},
			'{make_rq(REQ_WRITE, {2'd2, PORT_MODE}, 32'h230, '0, '0, 0), 0, '0, '0},
			'{make_rq(REQ_TICKS, '0, '0, 16'hFFFF, '0, 0), 0, '0, '0},
			'{make_rq(REQ_TICKS, '0, '0, 16'h0, '0, 0), 0, '0, '0},
			'{make_rq(REQ_WRITE, {2'd0, PORT_MODE}, 32'h1, '0, '0, 0), 0, '0, '0},
			'{make_rq(REQ_GATE, '0, '0, '0, 2'd0, 1), 0, '0, '0},
			'{make_rq(REQ_TICKS, '0, '0, 16'd9, '0, 0), 0, '0, '0},
			'{make_rq(REQ_WRITE, {2'd1, PORT_MODE}, 32'h3, '0, '0, 0), 0, '0, '0},
			'{make_rq(REQ_GATE, '0, '0, '0, 2'd1, 1), 0, '0, '0},
			'{make_rq(REQ_WRITE, {2'd2, PORT_MODE}, 32'h5, '0, '0, 0), 0, '0, '0},
			'{make_rq(REQ_GATE, '0, '0, '0, 2'd2, 1), 0, '0, '0},
			'{make_rq(REQ_WRITE, {2'd0, PORT_MODE}, 32'hFFFF_FFFF, '0, '0, 0), 0, '0, '0},
			'{make_rq(REQ_GATE, '0, '0, '0, 2'd3, 1), 1, 32'h0, 3'h0},
			'{make_rq(REQ_TICKS, '0, '0, 16'd100, '0, 0), 0, '0, '0}
		};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (rows[i]) issue(rows[i].rq, rows[i].typed, rows[i].rdata, rows[i].irq);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idling_on = !(i >= 300 && i < 500);
			issue(random_rq(), 1'b0, '0, '0);
		end
		in_valid = 1'b0;
		stimulus_done = 1'b1;
	end

	initial begin
		int unsigned held;
		held = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && accepted >= 800) begin
				out_stall = 1'b1;
				held++;
				if (held == HOLD_CYCLES) hold_done = 1'b1;
			end else begin
				out_stall = idling_on && $urandom_range(99) < 38;
			end
		end
	end

	always @(posedge clk) begin
		outcome_t exp_o;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: read_data %h irq_mask %h",
					$time, read_data, irq_mask);
				mismatches++;
			end else begin
				exp_o = pending_results.pop_front();
				if (read_data !== exp_o.rdata) begin
					$display("%0t: read_data expected %h actual %h", $time, exp_o.rdata,
						read_data);
					mismatches++;
				end
				if (irq_mask !== exp_o.irq) begin
					$display("%0t: irq_mask expected %h actual %h", $time, exp_o.irq,
						irq_mask);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		wait (stimulus_done);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/gtct_pkg.sv
rtl/gtct_div.sv
rtl/gated_triple_counter_timer.sv
sim/tb.sv
